/* sv/pwc_pkg.sv */
package pwc_pkg;

    localparam int PLANE_BITS = 16;
    localparam int COL_W      = 13;
    localparam int ROW_W      = 13;
    localparam int RW_W       = 14;
    localparam int AREA_W     = 27;
    localparam int ADDR_W     = 26;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic [PLANE_BITS-1:0] t_plane;
    typedef logic [ADDR_W-1:0]     t_addr;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STACK_DEPTH  = 2'd0,
        CFG_WINDOW_DEPTH = 2'd1,
        CFG_ROW_WIDTH    = 2'd2,
        CFG_PLANE_AREA   = 2'd3
    } t_cfg_idx;

    // Decision stage results, waiting on the address multiply.
    typedef struct packed {
        logic   hit;
        t_plane window_first;
        t_plane plane_in_window;
        t_plane move_from;
        t_plane move_to;
        t_plane move_count;
        t_plane load_first;
        t_plane load_slot;
        t_plane load_count;
        t_addr  row_offset;
    } t_mid;

endpackage

/* sv/plane_window_cache_policy.sv */
// Sliding window plane cache policy. Each item (col, row, plane) is checked against the
// window of window_depth planes starting at window_first. A hit leaves the window alone
// and all move/load commands read zero; a miss re-centers the window at
// max(0, plane - window_depth/2), clamped to stack_depth - window_depth, and reports which
// buffer slots to move and which stack planes to load. The first item after reset loads
// a full window. Every result also carries the plane's index in the window and the voxel
// word address plane_in_window*plane_area + row*row_width + col, modulo 2^26. The block
// takes one item per clock while i_out_ready does not stall the output, passing each item
// through three registers: input register, window decision (which also updates the window
// for the next item), then the plane-area multiply-add into the output register. The
// config port is always ready and must only be written while the block is idle.
module plane_window_cache_policy (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pwc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pwc_pkg::CFG_DATA_W-1:0]      i_cfg_data,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [pwc_pkg::COL_W-1:0]           i_col,
    input  logic [pwc_pkg::ROW_W-1:0]           i_row,
    input  logic [pwc_pkg::PLANE_BITS-1:0]      i_plane,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_hit,
    output logic [pwc_pkg::PLANE_BITS-1:0]      o_window_first,
    output logic [pwc_pkg::PLANE_BITS-1:0]      o_plane_in_window,
    output logic [pwc_pkg::ADDR_W-1:0]          o_voxel_address,
    output logic [pwc_pkg::PLANE_BITS-1:0]      o_move_from,
    output logic [pwc_pkg::PLANE_BITS-1:0]      o_move_to,
    output logic [pwc_pkg::PLANE_BITS-1:0]      o_move_count,
    output logic [pwc_pkg::PLANE_BITS-1:0]      o_load_first,
    output logic [pwc_pkg::PLANE_BITS-1:0]      o_load_slot,
    output logic [pwc_pkg::PLANE_BITS-1:0]      o_load_count
);

    localparam int P      = pwc_pkg::PLANE_BITS;
    localparam int RC_W   = pwc_pkg::ROW_W + pwc_pkg::RW_W + 1;
    localparam int PROD_W = P + pwc_pkg::AREA_W;

    // configuration
    pwc_pkg::t_plane                r_stack_depth;
    pwc_pkg::t_plane                r_window_depth;
    logic [pwc_pkg::RW_W-1:0]       r_row_width;
    logic [pwc_pkg::AREA_W-1:0]     r_plane_area;

    // window state
    pwc_pkg::t_plane                r_window_start;
    logic                           r_window_valid;

    // pipeline
    logic                           r_in_valid;
    logic [pwc_pkg::COL_W-1:0]      r_col;
    logic [pwc_pkg::ROW_W-1:0]      r_row;
    pwc_pkg::t_plane                r_plane;
    logic                           r_mid_valid;
    pwc_pkg::t_mid                  r_mid;
    pwc_pkg::t_mid                  n_mid;
    logic                           r_out_valid;
    pwc_pkg::t_mid                  r_out;
    pwc_pkg::t_addr                 r_addr;
    pwc_pkg::t_addr                 n_addr;

    logic                           out_adv;
    logic                           mid_adv;
    logic                           in_adv;

    assign out_adv = !r_out_valid || i_out_ready;
    assign mid_adv = !r_mid_valid || out_adv;
    assign in_adv  = !r_in_valid || mid_adv;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_depth  <= '0;
            r_window_depth <= '0;
            r_row_width    <= '0;
            r_plane_area   <= '0;
        end else if (i_cfg_valid) begin
            case (pwc_pkg::t_cfg_idx'(i_cfg_index))
                pwc_pkg::CFG_STACK_DEPTH:  r_stack_depth  <= i_cfg_data[P-1:0];
                pwc_pkg::CFG_WINDOW_DEPTH: r_window_depth <= i_cfg_data[P-1:0];
                pwc_pkg::CFG_ROW_WIDTH:    r_row_width    <= i_cfg_data[pwc_pkg::RW_W-1:0];
                pwc_pkg::CFG_PLANE_AREA:   r_plane_area   <= i_cfg_data[pwc_pkg::AREA_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- window decision ----------------
    logic [P+1:0]     c_diff;
    pwc_pkg::t_plane  c_st0;
    pwc_pkg::t_plane  c_lim;
    logic             c_s_lt_d;
    pwc_pkg::t_plane  c_ns;
    logic [P:0]       c_old_end;
    logic [P:0]       c_ns_end;
    logic [P:0]       c_keep_dn;
    pwc_pkg::t_plane  c_shift;
    pwc_pkg::t_plane  c_keep;
    logic             c_hit;
    logic [RC_W-1:0]  c_rc;

    always_comb begin
        c_old_end = {1'b0, r_window_start} + {1'b0, r_window_depth};
        c_hit     = r_window_valid && (r_plane >= r_window_start)
                    && ({1'b0, r_plane} < c_old_end);

        c_diff   = {2'b00, r_plane} - {3'b000, r_window_depth[P-1:1]};
        c_st0    = c_diff[P+1] ? '0 : c_diff[P-1:0];
        c_s_lt_d = r_stack_depth < r_window_depth;
        c_lim    = r_stack_depth - r_window_depth;
        // window bigger than the stack pins the start at 0
        if (c_hit)
            c_ns = r_window_start;
        else if (c_s_lt_d)
            c_ns = '0;
        else
            c_ns = (c_st0 > c_lim) ? c_lim : c_st0;

        c_ns_end  = {1'b0, c_ns} + {1'b0, r_window_depth};
        c_keep_dn = c_ns_end - {1'b0, r_window_start};
        c_shift   = c_ns - r_window_start;
        c_keep    = '0;

        n_mid                 = '0;
        n_mid.hit             = c_hit;
        n_mid.window_first    = c_ns;
        n_mid.plane_in_window = r_plane - c_ns;

        if (!c_hit) begin
            if (!r_window_valid) begin
                n_mid.load_first = c_ns;
                n_mid.load_count = r_window_depth;
            end else if (c_ns != r_window_start) begin
                n_mid.load_first = c_ns;
                if (c_ns > r_window_start) begin
                    if ({1'b0, c_ns} < c_old_end) begin
                        // window slides up: tail of old window moves to slot 0
                        c_keep           = r_window_depth - c_shift;
                        n_mid.move_from  = c_shift;
                        n_mid.load_slot  = c_keep;
                        n_mid.load_first = c_old_end[P-1:0];
                    end
                end else if (c_ns_end > {1'b0, r_window_start}) begin
                    // window slides down: head of old window moves up
                    c_keep        = c_keep_dn[P-1:0];
                    n_mid.move_to = r_window_start - c_ns;
                end
                n_mid.move_count = c_keep;
                n_mid.load_count = r_window_depth - c_keep;
            end
        end

        c_rc = RC_W'(r_row) * RC_W'(r_row_width) + RC_W'(r_col);
        n_mid.row_offset = c_rc[pwc_pkg::ADDR_W-1:0];
    end

    // ---------------- address multiply-add ----------------
    logic [PROD_W-1:0] c_prod;

    always_comb begin
        c_prod = PROD_W'(r_mid.plane_in_window) * PROD_W'(r_plane_area);
        n_addr = c_prod[pwc_pkg::ADDR_W-1:0] + r_mid.row_offset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_mid_valid    <= 1'b0;
            r_out_valid    <= 1'b0;
            r_window_start <= '0;
            r_window_valid <= 1'b0;
        end else begin
            if (in_adv)
                r_in_valid <= i_in_valid;
            if (mid_adv)
                r_mid_valid <= r_in_valid;
            if (out_adv)
                r_out_valid <= r_mid_valid;
            if (mid_adv && r_in_valid) begin
                r_window_start <= c_ns;
                r_window_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_col   <= i_col;
            r_row   <= i_row;
            r_plane <= i_plane;
        end
        if (mid_adv)
            r_mid <= n_mid;
        if (out_adv) begin
            r_out  <= r_mid;
            r_addr <= n_addr;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_hit             = r_out.hit;
    assign o_window_first    = r_out.window_first;
    assign o_plane_in_window = r_out.plane_in_window;
    assign o_voxel_address   = r_addr;
    assign o_move_from       = r_out.move_from;
    assign o_move_to         = r_out.move_to;
    assign o_move_count      = r_out.move_count;
    assign o_load_first      = r_out.load_first;
    assign o_load_slot       = r_out.load_slot;
    assign o_load_count      = r_out.load_count;

endmodule
